### hw/rtl/ita_pkg.sv
package ita_pkg;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [31:0] value;
   } ita_req_word_type;

   typedef struct packed {
      logic [6:0] text_char;
      logic       last;
      logic [3:0] char_count;
   } ita_rsp_word_type;

   localparam logic [1:0] FMT_UDEC = 2'd0;
   localparam logic [1:0] FMT_SDEC = 2'd1;
   localparam logic [1:0] FMT_HEXU = 2'd2;
   localparam logic [1:0] FMT_HEXL = 2'd3;

   localparam logic [6:0] CHAR_ZERO    = 7'd48;
   localparam logic [6:0] CHAR_UPPER_A = 7'd65;
   localparam logic [6:0] CHAR_LOWER_A = 7'd97;
   localparam logic [6:0] CHAR_MINUS   = 7'd45;
   localparam logic [6:0] DEC_RADIX    = 7'd10;

   localparam int COUNT_W = 5;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_COUNT,
      ST_EMIT
   } ita_state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic count;
      logic emit;
   } ita_cmd_type;

   typedef struct packed {
      logic req_hex;
      logic conv_done;
      logic sign_pend;
      logic ptr_zero;
      logic out_free;
   } ita_status_type;

endpackage

### hw/rtl/ita_ctrl.sv
module ita_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  ita_pkg::ita_status_type status,
   output ita_pkg::ita_cmd_type    cmd
);
   import ita_pkg::*;

   ita_state_type state_ff;
   ita_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = status.req_hex ? ST_COUNT : ST_CONV;
            end
         end
         ST_CONV: begin
            if (status.conv_done) begin
               state_in = ST_COUNT;
            end
         end
         ST_COUNT: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free && !status.sign_pend && status.ptr_zero) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      cmd.load  = (state_ff == ST_IDLE) && req_valid;
      cmd.step  = (state_ff == ST_CONV);
      cmd.count = (state_ff == ST_COUNT);
      cmd.emit  = (state_ff == ST_EMIT) && status.out_free;
   end

endmodule

### hw/rtl/ita_dp.sv
module ita_dp #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  ita_pkg::ita_req_word_type req_data,
   input  ita_pkg::ita_cmd_type      cmd,
   output ita_pkg::ita_status_type   status,
   input  logic                      rsp_stall,
   output logic                      rsp_valid,
   output ita_pkg::ita_rsp_word_type rsp_data
);
   import ita_pkg::*;

   localparam int NDIG_DEC = (VALUE_WIDTH * 30103) / 100000 + 1;
   localparam int NDIG_HEX = (VALUE_WIDTH + 3) / 4;
   localparam int NDIG     = (NDIG_DEC > NDIG_HEX) ? NDIG_DEC : NDIG_HEX;
   localparam int PW       = $clog2(NDIG);
   localparam int BCW      = $clog2(VALUE_WIDTH + 1);

   logic [VALUE_WIDTH+31:0]  val_wide;
   logic [VALUE_WIDTH-1:0]   val;
   logic                     neg_load;
   logic [NDIG_HEX*4-1:0]    hex_ext;
   logic [NDIG-1:0][3:0]     hex_digits;
   logic [NDIG-1:0][3:0]     adj;
   logic [NDIG*4-1:0]        adj_flat;
   logic [PW:0]              nd;
   logic [3:0]               cur_digit;
   logic [6:0]               cur_char;

   logic [VALUE_WIDTH-1:0]   mag_ff, mag_in;
   logic [NDIG-1:0][3:0]     digits_ff, digits_in;
   logic [BCW-1:0]           bit_cnt_ff, bit_cnt_in;
   logic                     neg_ff, neg_in;
   logic                     lower_ff, lower_in;
   logic [PW-1:0]            ptr_ff, ptr_in;
   logic [COUNT_W-1:0]       total_ff, total_in;
   logic                     sign_pend_ff, sign_pend_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   ita_rsp_word_type         rsp_ff, rsp_in;

   always_comb begin
      val_wide = {{VALUE_WIDTH{1'b0}}, req_data.value};
      val      = val_wide[VALUE_WIDTH-1:0];
      neg_load = (req_data.req_type == FMT_SDEC) && val[VALUE_WIDTH-1];
      hex_ext  = (NDIG_HEX*4)'(val);
      hex_digits = '0;
      for (int i = 0; i < NDIG_HEX; i++) begin
         hex_digits[i] = hex_ext[4*i +: 4];
      end
      for (int i = 0; i < NDIG; i++) begin
         adj[i] = (digits_ff[i] >= 4'd5) ? (digits_ff[i] + 4'd3) : digits_ff[i];
      end
      adj_flat = adj;
      nd = (PW+1)'(1);
      for (int i = 0; i < NDIG; i++) begin
         if (digits_ff[i] != 4'd0) begin
            nd = (PW+1)'(i + 1);
         end
      end
      cur_digit = digits_ff[ptr_ff];
      if (cur_digit > 4'd9) begin
         cur_char = (lower_ff ? CHAR_LOWER_A : CHAR_UPPER_A) + 7'(cur_digit) - DEC_RADIX;
      end else begin
         cur_char = CHAR_ZERO + 7'(cur_digit);
      end
   end

   always_comb begin
      mag_in       = mag_ff;
      digits_in    = digits_ff;
      bit_cnt_in   = bit_cnt_ff;
      neg_in       = neg_ff;
      lower_in     = lower_ff;
      ptr_in       = ptr_ff;
      total_in     = total_ff;
      sign_pend_in = sign_pend_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.load) begin
         neg_in     = neg_load;
         lower_in   = (req_data.req_type == FMT_HEXL);
         mag_in     = neg_load ? (~val + VALUE_WIDTH'(1)) : val;
         bit_cnt_in = BCW'(VALUE_WIDTH);
         digits_in  = req_data.req_type[1] ? hex_digits : '0;
      end
      if (cmd.step) begin
         digits_in  = {adj_flat[NDIG*4-2:0], mag_ff[VALUE_WIDTH-1]};
         mag_in     = {mag_ff[VALUE_WIDTH-2:0], 1'b0};
         bit_cnt_in = bit_cnt_ff - BCW'(1);
      end
      if (cmd.count) begin
         ptr_in       = PW'(nd - (PW+1)'(1));
         total_in     = COUNT_W'(nd) + COUNT_W'(neg_ff);
         sign_pend_in = neg_ff;
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         if (sign_pend_ff) begin
            rsp_in.text_char = CHAR_MINUS;
            rsp_in.last      = 1'b0;
            rsp_in.char_count = 4'd0;
            sign_pend_in     = 1'b0;
         end else begin
            rsp_in.text_char  = cur_char;
            rsp_in.last       = (ptr_ff == '0);
            rsp_in.char_count = (ptr_ff == '0) ? total_ff[3:0] : 4'd0;
            ptr_in            = ptr_ff - PW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff       <= mag_in;
      digits_ff    <= digits_in;
      bit_cnt_ff   <= bit_cnt_in;
      neg_ff       <= neg_in;
      lower_ff     <= lower_in;
      ptr_ff       <= ptr_in;
      total_ff     <= total_in;
      sign_pend_ff <= sign_pend_in;
      rsp_ff       <= rsp_in;
   end

   always_comb begin
      status.req_hex   = req_data.req_type[1];
      status.conv_done = (bit_cnt_ff == BCW'(1));
      status.sign_pend = sign_pend_ff;
      status.ptr_zero  = (ptr_ff == '0);
      status.out_free  = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### hw/rtl/integer_to_ascii_formatter_top.sv
// Channel   Direction  Handshake             Word
// req       in         req_valid/req_stall   req_data  (format, value)
// rsp       out        rsp_valid/rsp_stall   rsp_data  (character, last, count)
//
// A decimal word takes a load step, the shift-and-adjust steps of the binary-to-BCD
// converter and a digit-count step, then one character per cycle unless rsp stalls.
// A hex word skips the converter: load and digit-count steps, then characters as above.
// Reset clears the controller state and the output valid flag.
// A stall on rsp holds the output register; a new req word is taken once the last
// character of the previous word sits in the output register.
module integer_to_ascii_formatter_top #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  ita_pkg::ita_req_word_type req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output ita_pkg::ita_rsp_word_type rsp_data
);
   import ita_pkg::*;

   ita_cmd_type    cmd;
   ita_status_type status;

   ita_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ita_dp #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

`ifndef NO_ASSERTIONS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("block accepted a word without going busy");

   a_count_only_on_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.last) |-> (rsp_data.char_count == 4'd0))
      else $error("character count set on a character that is not last");

   a_last_has_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.last) |-> (rsp_data.char_count != 4'd0))
      else $error("last character carries a zero count");

   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.text_char == CHAR_MINUS)) |-> !rsp_data.last)
      else $error("minus sign marked as last character");
`endif

endmodule
